// File: src/cpid_pkg.sv
package cpid_pkg;

   // Default sample width of setpoint and measurement.
   localparam int SAMPLE_WIDTH_DEFAULT = 16;

   // Fixed field widths.
   localparam int DRIVE_WIDTH     = 16;
   localparam int GAIN_WIDTH      = 10;
   localparam int OUT_LIMIT_WIDTH = 15;
   localparam int LIMIT_WIDTH     = 16;
   localparam int SUM_WIDTH       = 18;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   // Largest magnitude the stored error sum can reach.
   localparam int SUM_MAGNITUDE_MAX = 65535;

   // Register reset values.
   localparam logic [GAIN_WIDTH-1:0]      GAIN_RESET         = '0;
   localparam logic [OUT_LIMIT_WIDTH-1:0] OUTPUT_LIMIT_RESET = 15'd32767;
   localparam logic [LIMIT_WIDTH-1:0]     ERROR_LIMIT_RESET  = 16'd200;
   localparam logic [LIMIT_WIDTH-1:0]     PROP_LIMIT_RESET   = 16'd500;
   localparam logic [LIMIT_WIDTH-1:0]     SUM_LIMIT_RESET    = 16'd200;
   localparam logic [LIMIT_WIDTH-1:0]     INTEG_LIMIT_RESET  = 16'd100;

   // Most negative drive code; the clamp never produces it.
   localparam logic [DRIVE_WIDTH-1:0] DRIVE_MOST_NEGATIVE = 16'h8000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PROP_GAIN    = 3'd0,
      CSR_INTEG_GAIN   = 3'd1,
      CSR_DERIV_GAIN   = 3'd2,
      CSR_OUTPUT_LIMIT = 3'd3,
      CSR_ERROR_LIMIT  = 3'd4,
      CSR_PROP_LIMIT   = 3'd5,
      CSR_SUM_LIMIT    = 3'd6,
      CSR_INTEG_LIMIT  = 3'd7
   } csr_index_type;

endpackage

// File: src/cpid_stream_if.sv
// Request channel: one beat carries a setpoint and a measurement.
interface cpid_req_if #(
   parameter int SAMPLE_WIDTH = cpid_pkg::SAMPLE_WIDTH_DEFAULT
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] setpoint;
   logic signed [SAMPLE_WIDTH-1:0] measurement;

   modport source (output valid, output setpoint, output measurement, input ready);
   modport sink   (input valid, input setpoint, input measurement, output ready);
endinterface

// Response channel: one beat carries the clamped drive value.
interface cpid_rsp_if;
   import cpid_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [DRIVE_WIDTH-1:0] drive;

   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

// File: src/clamped_pid_controller_top.sv
// Clamped PID controller with anti-windup, one drive value per request beat.
// A request beat passes the input register, then one pass of error, three multiplies,
// sum and clamp into the result register, from which its response beat is offered.
// Throughput: one beat per cycle while the response side keeps taking beats.
// Reset (synchronous, active high) clears both pipeline valids, the error sum and the
// last measurement, and returns all configuration registers to their reset values.
module clamped_pid_controller_top #(
   parameter int SAMPLE_WIDTH = cpid_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   cpid_req_if.sink                            req_bus,
   cpid_rsp_if.source                          rsp_bus,
   input  logic                                csr_wr_en,
   input  cpid_pkg::csr_index_type             csr_index,
   input  logic [cpid_pkg::CSR_DATA_WIDTH-1:0] csr_wr_data
);
   import cpid_pkg::*;

   // Working widths. The error needs one bit over a sample; each product adds the
   // signed gain width; the total leaves headroom for three terms so that nothing
   // wraps before the final clamp. All comparisons happen at the total width.
   localparam int ERR_W = SAMPLE_WIDTH + 1;
   localparam int T_W   = ((ERR_W > SUM_WIDTH) ? ERR_W : SUM_WIDTH) + 1;
   localparam int P_W   = ERR_W + GAIN_WIDTH + 1;
   localparam int I_W   = SUM_WIDTH + GAIN_WIDTH + 1;
   localparam int TOT_W = ((P_W > I_W) ? P_W : I_W) + 2;

   // Configuration registers.
   logic [GAIN_WIDTH-1:0]      prop_gain_ff,    prop_gain_in;
   logic [GAIN_WIDTH-1:0]      integ_gain_ff,   integ_gain_in;
   logic [GAIN_WIDTH-1:0]      deriv_gain_ff,   deriv_gain_in;
   logic [OUT_LIMIT_WIDTH-1:0] output_limit_ff, output_limit_in;
   logic [LIMIT_WIDTH-1:0]     error_limit_ff,  error_limit_in;
   logic [LIMIT_WIDTH-1:0]     prop_limit_ff,   prop_limit_in;
   logic [LIMIT_WIDTH-1:0]     sum_limit_ff,    sum_limit_in;
   logic [LIMIT_WIDTH-1:0]     integ_limit_ff,  integ_limit_in;

   // Controller state.
   logic signed [SUM_WIDTH-1:0]    error_sum_ff, error_sum_in;
   logic signed [SAMPLE_WIDTH-1:0] last_meas_ff, last_meas_in;

   // Input register stage.
   logic                           in_valid_ff, in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] setpoint_ff, setpoint_in;
   logic signed [SAMPLE_WIDTH-1:0] meas_ff,     meas_in;

   // Result register stage.
   logic                          out_valid_ff, out_valid_in;
   logic signed [DRIVE_WIDTH-1:0] drive_ff,     drive_in;

   // Handshake.
   logic req_accept;
   logic out_advance;
   logic stage_fire;

   // Datapath.
   logic signed [ERR_W-1:0]     err;
   logic signed [ERR_W-1:0]     meas_delta;
   logic signed [T_W-1:0]       sum_trial;
   logic signed [SUM_WIDTH-1:0] sum_trunc;
   logic signed [SUM_WIDTH-1:0] ilim_sum;
   logic signed [GAIN_WIDTH:0]  prop_gain_s;
   logic signed [GAIN_WIDTH:0]  integ_gain_s;
   logic signed [GAIN_WIDTH:0]  deriv_gain_s;
   logic signed [P_W-1:0]       p_prod;
   logic signed [I_W-1:0]       i_prod;
   logic signed [P_W-1:0]       d_prod;
   logic signed [TOT_W-1:0]     err_x;
   logic signed [TOT_W-1:0]     sum_x;
   logic signed [TOT_W-1:0]     elim_x;
   logic signed [TOT_W-1:0]     plim_x;
   logic signed [TOT_W-1:0]     slim_x;
   logic signed [TOT_W-1:0]     ilim_x;
   logic signed [TOT_W-1:0]     olim_x;
   logic signed [TOT_W-1:0]     p_term;
   logic signed [TOT_W-1:0]     i_term;
   logic signed [TOT_W-1:0]     d_term;
   logic signed [TOT_W-1:0]     total;
   logic signed [TOT_W-1:0]     total_clamped;

   // The input register may take a new beat whenever it is empty or its
   // contents move into the result register in the same cycle, so a
   // response waiting on the output does not stop the input by itself.
   assign out_advance   = !out_valid_ff || rsp_bus.ready;
   assign stage_fire    = in_valid_ff && out_advance;
   assign req_bus.ready = !in_valid_ff || out_advance;
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.drive = drive_ff;

   // Configuration writes. Values wider than a register are truncated.
   always_comb begin
      prop_gain_in    = prop_gain_ff;
      integ_gain_in   = integ_gain_ff;
      deriv_gain_in   = deriv_gain_ff;
      output_limit_in = output_limit_ff;
      error_limit_in  = error_limit_ff;
      prop_limit_in   = prop_limit_ff;
      sum_limit_in    = sum_limit_ff;
      integ_limit_in  = integ_limit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PROP_GAIN:    prop_gain_in    = csr_wr_data[GAIN_WIDTH-1:0];
            CSR_INTEG_GAIN:   integ_gain_in   = csr_wr_data[GAIN_WIDTH-1:0];
            CSR_DERIV_GAIN:   deriv_gain_in   = csr_wr_data[GAIN_WIDTH-1:0];
            CSR_OUTPUT_LIMIT: output_limit_in = csr_wr_data[OUT_LIMIT_WIDTH-1:0];
            CSR_ERROR_LIMIT:  error_limit_in  = csr_wr_data[LIMIT_WIDTH-1:0];
            CSR_PROP_LIMIT:   prop_limit_in   = csr_wr_data[LIMIT_WIDTH-1:0];
            CSR_SUM_LIMIT:    sum_limit_in    = csr_wr_data[LIMIT_WIDTH-1:0];
            CSR_INTEG_LIMIT:  integ_limit_in  = csr_wr_data[LIMIT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Limits and gains as non-negative signed values at the working width.
   always_comb begin
      elim_x       = TOT_W'($signed({1'b0, error_limit_ff}));
      plim_x       = TOT_W'($signed({1'b0, prop_limit_ff}));
      slim_x       = TOT_W'($signed({1'b0, sum_limit_ff}));
      ilim_x       = TOT_W'($signed({1'b0, integ_limit_ff}));
      olim_x       = TOT_W'($signed({1'b0, output_limit_ff}));
      ilim_sum     = SUM_WIDTH'($signed({1'b0, integ_limit_ff}));
      prop_gain_s  = $signed({1'b0, prop_gain_ff});
      integ_gain_s = $signed({1'b0, integ_gain_ff});
      deriv_gain_s = $signed({1'b0, deriv_gain_ff});
   end

   // One control step for the beat in the input register.
   always_comb begin
      err        = ERR_W'(setpoint_ff) - ERR_W'(meas_ff);
      meas_delta = ERR_W'(last_meas_ff) - ERR_W'(meas_ff);
      sum_trial  = T_W'(error_sum_ff) + T_W'(err);
      err_x      = TOT_W'(err);
      sum_x      = TOT_W'(sum_trial);
      // Within the sum limit the trial sum fits the stored sum width.
      sum_trunc  = sum_trial[SUM_WIDTH-1:0];

      p_prod = prop_gain_s * err;
      i_prod = integ_gain_s * sum_trunc;
      d_prod = deriv_gain_s * meas_delta;

      // Proportional term saturates when the error leaves the error window.
      if (err_x > elim_x) begin
         p_term = plim_x;
      end else if (err_x < -elim_x) begin
         p_term = -plim_x;
      end else begin
         p_term = TOT_W'(p_prod);
      end

      // Anti-windup: past the sum window both the term and the stored sum
      // take the integral limit rather than the sum limit.
      if (sum_x > slim_x) begin
         i_term       = ilim_x;
         error_sum_in = ilim_sum;
      end else if (sum_x < -slim_x) begin
         i_term       = -ilim_x;
         error_sum_in = -ilim_sum;
      end else begin
         i_term       = TOT_W'(i_prod);
         error_sum_in = sum_trunc;
      end

      d_term = TOT_W'(d_prod);
      total  = p_term + i_term + d_term;

      if (total > olim_x) begin
         total_clamped = olim_x;
      end else if (total < -olim_x) begin
         total_clamped = -olim_x;
      end else begin
         total_clamped = total;
      end

      last_meas_in = meas_ff;
      drive_in     = total_clamped[DRIVE_WIDTH-1:0];
   end

   // Pipeline control next values.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (stage_fire) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (stage_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      setpoint_in = req_bus.setpoint;
      meas_in     = req_bus.measurement;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff    <= GAIN_RESET;
         integ_gain_ff   <= GAIN_RESET;
         deriv_gain_ff   <= GAIN_RESET;
         output_limit_ff <= OUTPUT_LIMIT_RESET;
         error_limit_ff  <= ERROR_LIMIT_RESET;
         prop_limit_ff   <= PROP_LIMIT_RESET;
         sum_limit_ff    <= SUM_LIMIT_RESET;
         integ_limit_ff  <= INTEG_LIMIT_RESET;
      end else begin
         prop_gain_ff    <= prop_gain_in;
         integ_gain_ff   <= integ_gain_in;
         deriv_gain_ff   <= deriv_gain_in;
         output_limit_ff <= output_limit_in;
         error_limit_ff  <= error_limit_in;
         prop_limit_ff   <= prop_limit_in;
         sum_limit_ff    <= sum_limit_in;
         integ_limit_ff  <= integ_limit_in;
      end
   end

   // The controller state moves only when a beat passes the compute stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         error_sum_ff <= '0;
         last_meas_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (stage_fire) begin
            error_sum_ff <= error_sum_in;
            last_meas_ff <= last_meas_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         setpoint_ff <= setpoint_in;
         meas_ff     <= meas_in;
      end
      if (stage_fire) begin
         drive_ff <= drive_in;
      end
   end

`ifndef SYNTHESIS
   // The stored sum is bounded by a 16-bit limit in every branch.
   a_sum_bounded: assert property (@(posedge clock) disable iff (reset)
      (error_sum_ff <= SUM_MAGNITUDE_MAX) && (error_sum_ff >= -SUM_MAGNITUDE_MAX))
      else $error("error sum out of range");

   // The symmetric clamp never yields the most negative code.
   a_drive_symmetric: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.drive != DRIVE_MOST_NEGATIVE))
      else $error("drive outside the symmetric clamp");

   // A held input beat blocks new beats so none is overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_advance) |-> !req_bus.ready)
      else $error("input register overwritten");

   // The measurement of a beat becomes the next beat's last measurement.
   a_last_meas: assert property (@(posedge clock) disable iff (reset)
      stage_fire |=> (last_meas_ff == $past(meas_ff)))
      else $error("last measurement not updated");
`endif

endmodule

// File: tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cpid_pkg::*;

   // Sample range of the request fields.
   localparam int SW         = SAMPLE_WIDTH_DEFAULT;
   localparam int SAMPLE_MAX = (1 << (SW - 1)) - 1;
   localparam int SAMPLE_MIN = -(1 << (SW - 1));
   localparam longint ERR_SPAN = (longint'(1) << SW) - 1;

   // Shape of the random part: several configuration phases, each a run of beats.
   localparam int RANDOM_PHASES   = 27;
   localparam int BEATS_PER_PHASE = 50;
   localparam int MAX_GAP         = 10;
   // Margin for the pipeline to settle after the last owed drive beat is taken.
   localparam int SETTLE_CYCLES   = 4;

   typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_type;

   typedef struct {
      row_kind_type                kind;
      csr_index_type               index;
      logic [CSR_DATA_WIDTH-1:0]   data;
      logic signed [SW-1:0]        setpoint;
      logic signed [SW-1:0]        measurement;
      bit                          drive_known;
      logic signed [DRIVE_WIDTH-1:0] drive;
   } directed_row_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_wr_en;
   csr_index_type             csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_wr_data;

   cpid_req_if #(.SAMPLE_WIDTH(SW)) req_bus ();
   cpid_rsp_if                      rsp_bus ();

   clamped_pid_controller_top #(.SAMPLE_WIDTH(SW)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // The testbench keeps its own copy of the registers and of the two stores of
   // the controller (error sum and last measurement), and advances them once per
   // accepted request beat.
   longint reg_value [0:7];
   longint pid_error_sum;
   longint pid_last_meas;

   // Drive values still owed by the block, oldest first.
   logic signed [DRIVE_WIDTH-1:0] expected_drive [$];
   directed_row_type              directed_rows [$];
   int                            failures = 0;
   // While set, neither side inserts idle cycles, so the block runs at full rate.
   bit                            burst_phase = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // A generous bound: the slowest legal run needs well under a tenth of this.
   initial begin
      #4_000_000;
      $display("tb NOT OK");
      $finish;
   end

   // Field mask of each register; written data above the field is dropped.
   function automatic longint reg_mask(csr_index_type idx);
      case (idx)
         CSR_PROP_GAIN, CSR_INTEG_GAIN, CSR_DERIV_GAIN: return (longint'(1) << GAIN_WIDTH) - 1;
         CSR_OUTPUT_LIMIT: return (longint'(1) << OUT_LIMIT_WIDTH) - 1;
         default: return (longint'(1) << LIMIT_WIDTH) - 1;
      endcase
   endfunction

   // One control step: P, I and D terms computed without wrap, then the clamp.
   // The error sum and the last measurement are updated as a side effect.
   function automatic logic signed [DRIVE_WIDTH-1:0] next_drive(input longint sp,
                                                               input longint ms);
      longint err, p_term, i_term, d_term, run_sum, total, olim;
      err = sp - ms;
      // The P term saturates only strictly beyond the error limit.
      if (err > reg_value[CSR_ERROR_LIMIT])
         p_term = reg_value[CSR_PROP_LIMIT];
      else if (err < -reg_value[CSR_ERROR_LIMIT])
         p_term = -reg_value[CSR_PROP_LIMIT];
      else
         p_term = reg_value[CSR_PROP_GAIN] * err;
      // Anti-windup: beyond the sum limit the stored sum itself is replaced by
      // the I limit, and the I term is that limit with no gain applied.
      run_sum = pid_error_sum + err;
      if (run_sum > reg_value[CSR_SUM_LIMIT]) begin
         pid_error_sum = reg_value[CSR_INTEG_LIMIT];
         i_term = pid_error_sum;
      end else if (run_sum < -reg_value[CSR_SUM_LIMIT]) begin
         pid_error_sum = -reg_value[CSR_INTEG_LIMIT];
         i_term = pid_error_sum;
      end else begin
         pid_error_sum = run_sum;
         i_term = reg_value[CSR_INTEG_GAIN] * run_sum;
      end
      d_term = reg_value[CSR_DERIV_GAIN] * (pid_last_meas - ms);
      pid_last_meas = ms;
      total = p_term + i_term + d_term;
      olim = reg_value[CSR_OUTPUT_LIMIT];
      if (total > olim)
         total = olim;
      else if (total < -olim)
         total = -olim;
      return DRIVE_WIDTH'(total);
   endfunction

   function automatic void add_write(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] data);
      directed_row_type row;
      row = '{kind: ROW_WRITE, index: idx, data: data, setpoint: '0, measurement: '0,
              drive_known: 1'b0, drive: '0};
      directed_rows.push_back(row);
   endfunction

   // A known drive is typed in; otherwise the predictor decides.
   function automatic void add_beat(logic signed [SW-1:0] sp, logic signed [SW-1:0] ms,
                                    bit known, logic signed [DRIVE_WIDTH-1:0] drive);
      directed_row_type row;
      row = '{kind: ROW_BEAT, index: CSR_PROP_GAIN, data: '0, setpoint: sp,
              measurement: ms, drive_known: known, drive: drive};
      directed_rows.push_back(row);
   endfunction

   // Register writes happen at the falling edge and are seen by the block at the
   // next rising edge, after which the enable is dropped.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      reg_value[idx] = longint'(data) & reg_mask(idx);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Stop sending, wait for every owed drive beat, then let the pipeline settle.
   // This is also where the sender sits still until the block has fully drained.
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_drive.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Present one request beat after a random gap and hold it until accepted.
   task automatic send_beat(input logic signed [SW-1:0] sp, input logic signed [SW-1:0] ms,
                            input bit known, input logic signed [DRIVE_WIDTH-1:0] drive);
      int gap;
      logic signed [DRIVE_WIDTH-1:0] predicted;
      gap = burst_phase ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.setpoint    = sp;
      req_bus.measurement = ms;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      // The predictor always advances, even when the drive is typed in.
      predicted = next_drive(sp, ms);
      expected_drive.push_back(known ? drive : predicted);
   endtask

   function automatic logic [CSR_DATA_WIDTH-1:0] draw_reg_value(csr_index_type idx);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return CSR_DATA_WIDTH'(reg_mask(idx));
         2: return CSR_DATA_WIDTH'($urandom_range(0, 16));
         3: return CSR_DATA_WIDTH'($urandom_range(0, 400));
         // Full-width data, so bits above a narrow field are exercised as well.
         4: return CSR_DATA_WIDTH'($urandom);
         default: return CSR_DATA_WIDTH'($urandom_range(0, int'(reg_mask(idx))));
      endcase
   endfunction

   function automatic longint extreme_sample();
      logic signed [SW-1:0] raw;
      raw = SW'($urandom);
      case ($urandom_range(0, 5))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return raw;
      endcase
   endfunction

   // Most random beats follow a plant that moves slowly, with an error of at most
   // 300 either way, so the integrator and the clamps see long realistic runs. The
   // rest are full-range noise, corner samples and errors aimed exactly at the error
   // and sum limits or one step to either side of them.
   task automatic send_random_beat();
      longint err, sp, ms, lo, hi;
      logic signed [SW-1:0] raw_sp, raw_ms;
      int pick;
      pick = $urandom_range(0, 9);
      ms = pid_last_meas + longint'($urandom_range(0, 128)) - 64;
      err = longint'($urandom_range(0, 600)) - 300;
      case (pick)
         5: err = longint'($urandom_range(0, 8)) - 4;
         6, 7: begin
            raw_sp = SW'($urandom);
            raw_ms = SW'($urandom);
            err = longint'(raw_sp) - longint'(raw_ms);
            ms = raw_ms;
         end
         8: begin
            sp = extreme_sample();
            ms = extreme_sample();
            err = sp - ms;
         end
         9: begin
            case ($urandom_range(0, 3))
               0: err = reg_value[CSR_ERROR_LIMIT];
               1: err = -reg_value[CSR_ERROR_LIMIT];
               2: err = reg_value[CSR_SUM_LIMIT] - pid_error_sum;
               default: err = -reg_value[CSR_SUM_LIMIT] - pid_error_sum;
            endcase
            err = err + longint'($urandom_range(0, 2)) - 1;
         end
         default: ;
      endcase
      if (err > ERR_SPAN)
         err = ERR_SPAN;
      else if (err < -ERR_SPAN)
         err = -ERR_SPAN;
      // Place the measurement so that both samples stay in range.
      lo = (SAMPLE_MIN - err > SAMPLE_MIN) ? SAMPLE_MIN - err : SAMPLE_MIN;
      hi = (SAMPLE_MAX - err < SAMPLE_MAX) ? SAMPLE_MAX - err : SAMPLE_MAX;
      if (ms < lo)
         ms = lo;
      else if (ms > hi)
         ms = hi;
      sp = ms + err;
      send_beat(SW'(sp), SW'(ms), 1'b0, '0);
   endtask

   // Response side: stall for a random number of cycles before each beat, then
   // take the beat and compare it with the oldest owed drive value.
   initial begin
      int stall;
      logic signed [DRIVE_WIDTH-1:0] want;
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         stall = burst_phase ? 0 : $urandom_range(0, MAX_GAP);
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do
            @(posedge clock);
         while (rsp_bus.valid !== 1'b1);
         if (expected_drive.size() == 0) begin
            failures++;
            $display("%0t: drive beat %0d with none expected", $time, rsp_bus.drive);
         end else begin
            want = expected_drive.pop_front();
            if (rsp_bus.drive !== want) begin
               failures++;
               $display("%0t: drive mismatch, expected %0d, got %0d",
                        $time, want, rsp_bus.drive);
            end
         end
      end
   end

   // Request side and test sequence.
   initial begin
      csr_index_type idx;
      bit beats_pending;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = CSR_PROP_GAIN;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.setpoint    = '0;
      req_bus.measurement = '0;
      reg_value[CSR_PROP_GAIN]    = GAIN_RESET;
      reg_value[CSR_INTEG_GAIN]   = GAIN_RESET;
      reg_value[CSR_DERIV_GAIN]   = GAIN_RESET;
      reg_value[CSR_OUTPUT_LIMIT] = OUTPUT_LIMIT_RESET;
      reg_value[CSR_ERROR_LIMIT]  = ERROR_LIMIT_RESET;
      reg_value[CSR_PROP_LIMIT]   = PROP_LIMIT_RESET;
      reg_value[CSR_SUM_LIMIT]    = SUM_LIMIT_RESET;
      reg_value[CSR_INTEG_LIMIT]  = INTEG_LIMIT_RESET;
      pid_error_sum = 0;
      pid_last_meas = 0;
      beats_pending = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Straight after reset all gains are zero, so only saturated terms show:
      // a full-scale error gives the P limit plus the I limit, and an error that
      // sits exactly on the error limit is not saturated.
      add_beat(16'sd0, 16'sd0, 1'b1, 16'sd0);
      add_beat(16'sd32767, -16'sd32768, 1'b1, 16'sd600);
      add_beat(-16'sd32768, 16'sd32767, 1'b1, -16'sd600);
      add_beat(16'sd200, 16'sd0, 1'b1, 16'sd0);
      add_beat(16'sd0, 16'sd200, 1'b1, 16'sd0);
      // A zero output limit forces a zero drive whatever the gains.
      add_write(CSR_PROP_GAIN, 16'd1023);
      add_write(CSR_INTEG_GAIN, 16'd1023);
      add_write(CSR_DERIV_GAIN, 16'd1023);
      add_write(CSR_OUTPUT_LIMIT, 16'd0);
      add_beat(16'sd32767, -16'sd32768, 1'b1, 16'sd0);
      add_beat(-16'sd1, 16'sd5, 1'b1, 16'sd0);
      // Full-scale measurement swings drive the D term far past the clamp in
      // both directions; the negative clamp never reaches the most negative code.
      add_write(CSR_OUTPUT_LIMIT, 16'hFFFF);
      add_beat(16'sd32767, 16'sd32767, 1'b0, '0);
      add_beat(16'sd0, -16'sd32768, 1'b1, 16'sd32767);
      add_beat(16'sd0, 16'sd32767, 1'b1, -16'sd32767);
      // Error exactly on a small error limit, and one step past it on each side.
      add_write(CSR_PROP_GAIN, 16'd3);
      add_write(CSR_ERROR_LIMIT, 16'd10);
      add_write(CSR_PROP_LIMIT, 16'hFFFF);
      add_write(CSR_DERIV_GAIN, 16'd0);
      add_write(CSR_INTEG_GAIN, 16'd0);
      add_beat(16'sd10, 16'sd0, 1'b0, '0);
      add_beat(-16'sd10, 16'sd0, 1'b0, '0);
      add_beat(16'sd11, 16'sd0, 1'b0, '0);
      add_beat(-16'sd11, 16'sd0, 1'b0, '0);
      // The sum lands exactly on a sum limit of 20, then one past it, on both signs.
      add_write(CSR_INTEG_GAIN, 16'd5);
      add_write(CSR_SUM_LIMIT, 16'd20);
      add_write(CSR_INTEG_LIMIT, 16'd7);
      add_write(CSR_PROP_GAIN, 16'd0);
      add_write(CSR_PROP_LIMIT, 16'd0);
      add_beat(16'sd120, 16'sd0, 1'b0, '0);
      add_beat(16'sd1, 16'sd0, 1'b0, '0);
      add_beat(-16'sd27, 16'sd0, 1'b0, '0);
      add_beat(-16'sd1, 16'sd0, 1'b0, '0);
      // Error, P, sum and I limits at zero with large P and I gains.
      add_write(CSR_ERROR_LIMIT, 16'd0);
      add_write(CSR_SUM_LIMIT, 16'd0);
      add_write(CSR_INTEG_LIMIT, 16'd0);
      add_write(CSR_PROP_GAIN, 16'd1023);
      add_write(CSR_INTEG_GAIN, 16'd1023);
      add_beat(16'sd0, 16'sd0, 1'b0, '0);
      add_beat(16'sd1, 16'sd0, 1'b0, '0);
      add_beat(-16'sd1, 16'sd0, 1'b0, '0);

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_WRITE) begin
            // Registers change only with nothing in flight.
            if (beats_pending) begin
               wait_idle();
               beats_pending = 1'b0;
            end
            write_reg(directed_rows[k].index, directed_rows[k].data);
         end else begin
            send_beat(directed_rows[k].setpoint, directed_rows[k].measurement,
                      directed_rows[k].drive_known, directed_rows[k].drive);
            beats_pending = 1'b1;
         end
      end

      // Random phases: the first sets every register to all ones, the second to
      // zero, the rest to a mix of extremes, small values and full-width data.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         burst_phase = 1'b0;
         idx = idx.first();
         repeat (idx.num()) begin
            if (ph == 0)
               write_reg(idx, '1);
            else if (ph == 1)
               write_reg(idx, '0);
            else
               write_reg(idx, draw_reg_value(idx));
            idx = idx.next();
         end
         burst_phase = ($urandom_range(0, 3) == 0);
         repeat (BEATS_PER_PHASE) send_random_beat();
      end

      wait_idle();
      burst_phase = 1'b0;
      if (failures == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

// File: clamped_pid_controller_top.f
src/cpid_pkg.sv
src/cpid_stream_if.sv
src/clamped_pid_controller_top.sv
tb/sv/tb.sv
